@@ src/v3n_pkg.sv @@
// ----------------------------------------------------------------------------
// v3n_pkg
// Shared widths and stage types of the vector normaliser pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package v3n_pkg;

  // Number of vector components handled in parallel lanes.
  localparam int DimN  = 3;
  // Width of one input component, signed Q16.16.
  localparam int CompW = 32;
  // Width of one output component, signed Q1.16.
  localparam int UnitW = 18;
  // Width of the unsigned root magnitude, 0 .. 65536.
  localparam int RootW = 17;
  // Width of a component square.
  localparam int SqW   = 2 * CompW;
  // Width of the sum of squares, with headroom for up to eight components.
  localparam int SumW  = SqW + 2;
  // Width of the running product u * S, signed.
  localparam int ProdW = SumW + RootW + 5;
  // Width of the signed residual 2^34 * c^2 - u^2 * S.
  localparam int ResW  = 104;
  // Left shift that scales c^2 into the residual.
  localparam int ScaleSh = 34;

  // Per component working state of the digit recurrence.
  typedef struct packed {
    logic [RootW-1:0]        root;
    logic signed [ResW-1:0]  resid;
    logic signed [ProdW-1:0] prod;
  } lane_t;

  // Data travelling through the recurrence stages.
  typedef struct packed {
    logic                  zero;
    logic [DimN-1:0]       neg;
    logic [SumW-1:0]       sum;
    lane_t [DimN-1:0]      lane;
  } stage_t;

endpackage

`default_nettype wire

@@ src/v3n_in_if.sv @@
// ----------------------------------------------------------------------------
// v3n_in_if
// Input channel: one vector per transaction, components in signed Q16.16.
// ----------------------------------------------------------------------------
`default_nettype none

interface v3n_in_if;
  logic                    valid;
  logic                    ready;
  logic signed [31:0]      comp_x;
  logic signed [31:0]      comp_y;
  logic signed [31:0]      comp_z;

  modport source (output valid, output comp_x, output comp_y, output comp_z,
                  input ready);
  modport sink   (input valid, input comp_x, input comp_y, input comp_z,
                  output ready);
endinterface

`default_nettype wire

@@ src/v3n_out_if.sv @@
// ----------------------------------------------------------------------------
// v3n_out_if
// Result channel: unit vector in signed Q1.16 and a zero length flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface v3n_out_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] unit_x;
  logic signed [17:0] unit_y;
  logic signed [17:0] unit_z;
  logic               zero_length;

  modport source (output valid, output unit_x, output unit_y, output unit_z,
                  output zero_length, input ready);
  modport sink   (input valid, input unit_x, input unit_y, input unit_z,
                  input zero_length, output ready);
endinterface

`default_nettype wire

@@ src/vector3_normalizer.sv @@
// ----------------------------------------------------------------------------
// vector3_normalizer
// Unit vector of a three component Q16.16 vector, results in Q1.16.
// ----------------------------------------------------------------------------
// Usage:
//   vec_i carries one vector per transaction (comp_x, comp_y, comp_z).
//   res_o returns one transaction per vector, in order: unit_x, unit_y and
//   unit_z rounded to nearest (ties away from zero) and zero_length, which
//   is set with all components zero when the input vector is all zero.
//   From acceptance to res_o.valid a vector passes the registers for the
//   magnitudes, the squares and the sum of squares, then the bit-per-stage
//   root recurrence stages and the output register.
//   Throughput is one vector per cycle while res_o is not stalled; the seventeen
//   recurrence stages, each one wide subtract and compare, set the depth.
//   After reset the pipeline is empty and vec_i.ready is high.
//   When the receiver stalls, the whole pipeline holds; vec_i.ready stays
//   high while res_o is empty or being taken, so bubbles are absorbed.
// ----------------------------------------------------------------------------
`default_nettype none

module vector3_normalizer (
  input  wire     clk_i,
  input  wire     rst_ni,
  v3n_in_if.sink  vec_i,
  v3n_out_if.source res_o
);

  localparam int NStep = v3n_pkg::RootW;

  logic adv;
  logic signed [v3n_pkg::CompW-1:0] comp_w [v3n_pkg::DimN];

  logic                           v1_q, v2_q, v3_q, out_valid_q;
  logic [v3n_pkg::CompW-1:0]      mag1_q [v3n_pkg::DimN];
  logic [v3n_pkg::DimN-1:0]       neg1_q, neg2_q;
  logic [v3n_pkg::SqW-1:0]        sq2_q  [v3n_pkg::DimN];
  v3n_pkg::stage_t                stage3_d, stage3_q;

  logic                           step_v  [NStep+1];
  v3n_pkg::stage_t                step_st [NStep+1];

  logic signed [v3n_pkg::UnitW-1:0] unit_d [v3n_pkg::DimN];
  logic signed [v3n_pkg::UnitW-1:0] unit_q [v3n_pkg::DimN];
  logic                             zero_q;

  // The whole pipeline moves when the output register is free or taken.
  assign adv         = !out_valid_q || res_o.ready;
  assign vec_i.ready = adv;

  assign comp_w[0] = vec_i.comp_x;
  assign comp_w[1] = vec_i.comp_y;
  assign comp_w[2] = vec_i.comp_z;

  // Valid bits of the front stages and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= vec_i.valid;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= step_v[NStep];
    end
  end

  // Stage one: sign and magnitude; the most negative value maps to 2^31.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < v3n_pkg::DimN; i++) begin
        neg1_q[i] <= comp_w[i][v3n_pkg::CompW-1];
        mag1_q[i] <= comp_w[i][v3n_pkg::CompW-1] ? (~comp_w[i] + 1'b1) : comp_w[i];
      end
    end
  end

  // Stage two: one 32 by 32 square per lane.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      neg2_q <= neg1_q;
      for (int i = 0; i < v3n_pkg::DimN; i++) begin
        sq2_q[i] <= v3n_pkg::SqW'(mag1_q[i]) * v3n_pkg::SqW'(mag1_q[i]);
      end
    end
  end

  // Stage three: sum of squares and the starting point of the recurrence,
  // root 0 with u = -1, so the residual is 2^34*c^2 - S and P is -S.
  always_comb begin
    logic [v3n_pkg::SumW-1:0] acc;
    acc = '0;
    for (int i = 0; i < v3n_pkg::DimN; i++) begin
      acc = acc + v3n_pkg::SumW'(sq2_q[i]);
    end
    stage3_d.sum  = acc;
    stage3_d.zero = (acc == '0);
    stage3_d.neg  = neg2_q;
    for (int i = 0; i < v3n_pkg::DimN; i++) begin
      stage3_d.lane[i].root  = '0;
      stage3_d.lane[i].resid =
        $signed({{(v3n_pkg::ResW-v3n_pkg::SqW-v3n_pkg::ScaleSh){1'b0}}, sq2_q[i],
                 {v3n_pkg::ScaleSh{1'b0}}})
        - $signed({{(v3n_pkg::ResW-v3n_pkg::SumW){1'b0}}, acc});
      stage3_d.lane[i].prod  = -$signed({{(v3n_pkg::ProdW-v3n_pkg::SumW){1'b0}}, acc});
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      stage3_q <= stage3_d;
    end
  end

  assign step_v[0]  = v3_q;
  assign step_st[0] = stage3_q;

  // Root recurrence, most significant bit first.
  for (genvar g = 0; g < NStep; g++) begin : g_step
    v3n_step #(
      .BitK (NStep - 1 - g)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (step_v[g]),
      .stage_i (step_st[g]),
      .valid_o (step_v[g+1]),
      .stage_o (step_st[g+1])
    );
  end

  // Output stage: apply signs and force zero for a zero-length vector.
  always_comb begin
    for (int i = 0; i < v3n_pkg::DimN; i++) begin
      if (step_st[NStep].zero) begin
        unit_d[i] = '0;
      end else if (step_st[NStep].neg[i]) begin
        unit_d[i] = -$signed({1'b0, step_st[NStep].lane[i].root});
      end else begin
        unit_d[i] = $signed({1'b0, step_st[NStep].lane[i].root});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      unit_q <= unit_d;
      zero_q <= step_st[NStep].zero;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.unit_x      = unit_q[0];
  assign res_o.unit_y      = unit_q[1];
  assign res_o.unit_z      = unit_q[2];
  assign res_o.zero_length = zero_q;

  // An accepted transaction enters the first stage.
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vec_i.valid && vec_i.ready |=> v1_q)
    else $error("accepted vector did not enter the pipeline");

  // A zero-length result carries zero components.
  a_zero_outputs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.zero_length |->
      res_o.unit_x == '0 && res_o.unit_y == '0 && res_o.unit_z == '0)
    else $error("zero-length result with nonzero components");

  // Every component lies within plus or minus one.
  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |->
      res_o.unit_x >= -18'sd65536 && res_o.unit_x <= 18'sd65536 &&
      res_o.unit_y >= -18'sd65536 && res_o.unit_y <= 18'sd65536 &&
      res_o.unit_z >= -18'sd65536 && res_o.unit_z <= 18'sd65536)
    else $error("unit component out of range");

  // A stalled pipeline advances neither its first stage nor its last recurrence stage.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(v1_q) && $stable(step_v[NStep]))
    else $error("pipeline moved while stalled");

endmodule

`default_nettype wire

@@ src/v3n_step.sv @@
// ----------------------------------------------------------------------------
// v3n_step
// One registered stage of the root digit recurrence: decides one bit.
// ----------------------------------------------------------------------------
`default_nettype none

module v3n_step #(
  parameter int BitK = 16
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               en_i,
  input  wire               valid_i,
  input  v3n_pkg::stage_t   stage_i,
  output logic              valid_o,
  output v3n_pkg::stage_t   stage_o
);

  v3n_pkg::stage_t stage_d, stage_q;
  logic            valid_q;

  // Try setting bit BitK of each root: u grows by 2^(BitK+1), so the
  // residual drops by 2^(BitK+2)*P + 2^(2*BitK+2)*S. Keep the bit when the
  // residual stays non-negative. Once the root reaches 65536 no lower bit
  // may be added.
  always_comb begin
    logic signed [v3n_pkg::ResW-1:0] p_ext;
    logic signed [v3n_pkg::ResW-1:0] s_ext;
    logic signed [v3n_pkg::ResW-1:0] delta;
    logic signed [v3n_pkg::ResW-1:0] trial;
    logic                            skip;
    stage_d = stage_i;
    s_ext   = {{(v3n_pkg::ResW-v3n_pkg::SumW){1'b0}}, stage_i.sum};
    for (int i = 0; i < v3n_pkg::DimN; i++) begin
      p_ext = {{(v3n_pkg::ResW-v3n_pkg::ProdW){stage_i.lane[i].prod[v3n_pkg::ProdW-1]}},
               stage_i.lane[i].prod};
      delta = (p_ext <<< (BitK + 2)) + (s_ext << (2 * BitK + 2));
      trial = stage_i.lane[i].resid - delta;
      skip  = (BitK < v3n_pkg::RootW - 1) && stage_i.lane[i].root[v3n_pkg::RootW-1];
      if (!skip && !trial[v3n_pkg::ResW-1]) begin
        stage_d.lane[i].root[BitK] = 1'b1;
        stage_d.lane[i].resid      = trial;
        stage_d.lane[i].prod       = stage_i.lane[i].prod
                                     + v3n_pkg::ProdW'(s_ext << (BitK + 1));
      end
    end
  end

  // Valid bit is control state; the payload needs no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

`default_nettype wire
